// ===== hdl/mcmd_pkg.sv =====
`default_nettype none
package mcmd_pkg;

    // Register offsets
    localparam logic [7:0] ADDR_C_LO  = 8'h60;
    localparam logic [7:0] ADDR_C_HI  = 8'h61;
    localparam logic [7:0] ADDR_D_LO  = 8'h62;
    localparam logic [7:0] ADDR_D_HI  = 8'h63;
    localparam logic [7:0] ADDR_E_LO  = 8'h64;
    localparam logic [7:0] ADDR_E_HI  = 8'h65;
    localparam logic [7:0] ADDR_F_LO  = 8'h66;
    localparam logic [7:0] ADDR_F_HI  = 8'h67;
    localparam logic [7:0] ADDR_G_LO  = 8'h6C;
    localparam logic [7:0] ADDR_G_HI  = 8'h6D;
    localparam logic [7:0] ADDR_H_LO  = 8'h6E;
    localparam logic [7:0] ADDR_H_HI  = 8'h6F;
    localparam logic [7:0] ADDR_J_LO  = 8'h70;
    localparam logic [7:0] ADDR_J_HI  = 8'h71;
    localparam logic [7:0] ADDR_K_LO  = 8'h72;
    localparam logic [7:0] ADDR_K_HI  = 8'h73;
    localparam logic [7:0] ADDR_STAT  = 8'h92;

    localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

    // Status byte bits
    localparam int STAT_CARRY_BIT    = 2;
    localparam int STAT_OVERFLOW_BIT = 5;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Config register indexes
    localparam logic CFG_SIGNED_MODE = 1'b0;
    localparam logic CFG_ACCUM_MODE  = 1'b1;

    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic reg_write;  // byte write of the accepted beat
        logic load_out;   // capture read data into output register
        logic mul_start;  // magnitude product
        logic mul_fix;    // apply product sign
        logic mul_acc;    // optional accumulate, write G:H and flags
        logic div_pre;    // operand magnitudes, or divide-by-zero clear
        logic div_step;   // one restoring divide step
        logic div_post;   // quotient sign, write C, D, G, H
    } mcmd_cmd_t;

    typedef struct packed {
        logic divisor_zero;
    } mcmd_sts_t;

endpackage
`default_nettype wire

// ===== hdl/mcmd_ctrl.sv =====
`default_nettype none
module mcmd_ctrl
    import mcmd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       op,
    input  wire logic [7:0] reg_addr,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire mcmd_sts_t  sts,
    output mcmd_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MUL      = 3'd1;
    localparam logic [2:0] ST_MUL_FIX  = 3'd2;
    localparam logic [2:0] ST_MUL_ACC  = 3'd3;
    localparam logic [2:0] ST_DIV_PRE  = 3'd4;
    localparam logic [2:0] ST_DIV_LOOP = 3'd5;
    localparam logic [2:0] ST_DIV_POST = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.reg_write = (op == OP_WRITE);
                    if (op == OP_WRITE && reg_addr == ADDR_F_HI)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (op == OP_WRITE && reg_addr == ADDR_K_HI)
                    begin
                        state_next = ST_DIV_PRE;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_MUL_FIX;
            end
            ST_MUL_FIX:
            begin
                cmd.mul_fix = 1'b1;
                state_next  = ST_MUL_ACC;
            end
            ST_MUL_ACC:
            begin
                cmd.mul_acc = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_DIV_PRE:
            begin
                cmd.div_pre = 1'b1;
                cnt_next    = '0;
                state_next  = sts.divisor_zero ? ST_IDLE : ST_DIV_LOOP;
            end
            ST_DIV_LOOP:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DIV_POST;
                end
            end
            ST_DIV_POST:
            begin
                cmd.div_post = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mcmd_datapath.sv =====
`default_nettype none
module mcmd_datapath
    import mcmd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic       cfg_data,
    input  wire logic       op,
    input  wire logic [7:0] reg_addr,
    input  wire logic [7:0] write_byte,
    input  wire mcmd_cmd_t  cmd,
    output mcmd_sts_t       sts,
    output logic [7:0]      read_byte
);

    logic [15:0] c_reg, d_reg, e_reg, f_reg, g_reg, h_reg, j_reg, k_reg;
    logic [15:0] c_next, d_next, e_next, f_next, g_next, h_next, j_next, k_next;
    logic        carry_reg, carry_next, ovf_reg, ovf_next;
    logic        signed_reg, accum_reg;

    logic [31:0] prod_reg, prod_next;
    logic [31:0] dvd_reg, dvd_next;   // dividend, shifts out; quotient shifts in
    logic [15:0] dvs_reg, dvs_next;
    logic [15:0] rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic [7:0]  out_reg;

    logic [7:0]  rd_mux;
    logic [15:0] mag_c, mag_e;
    logic [31:0] gh, mag_gh, quo;
    logic [32:0] acc_sum;
    logic [16:0] part, diff;

    assign gh     = {g_reg, h_reg};
    assign mag_c  = (signed_reg && c_reg[15]) ? (16'd0 - c_reg) : c_reg;
    assign mag_e  = (signed_reg && e_reg[15]) ? (16'd0 - e_reg) : e_reg;
    assign mag_gh = (signed_reg && gh[31]) ? (32'd0 - gh) : gh;
    assign acc_sum = {1'b0, prod_reg} + {1'b0, gh};
    assign part   = {rem_reg, dvd_reg[31]};
    assign diff   = part - {1'b0, dvs_reg};
    assign quo    = neg_reg ? (32'd0 - dvd_reg) : dvd_reg;
    assign sts.divisor_zero = (e_reg == 16'd0);

    always_comb
    begin
        case (reg_addr)
            ADDR_C_LO: rd_mux = c_reg[7:0];
            ADDR_C_HI: rd_mux = c_reg[15:8];
            ADDR_D_LO: rd_mux = d_reg[7:0];
            ADDR_D_HI: rd_mux = d_reg[15:8];
            ADDR_E_LO: rd_mux = e_reg[7:0];
            ADDR_E_HI: rd_mux = e_reg[15:8];
            ADDR_F_LO: rd_mux = f_reg[7:0];
            ADDR_F_HI: rd_mux = f_reg[15:8];
            ADDR_G_LO: rd_mux = g_reg[7:0];
            ADDR_G_HI: rd_mux = g_reg[15:8];
            ADDR_H_LO: rd_mux = h_reg[7:0];
            ADDR_H_HI: rd_mux = h_reg[15:8];
            ADDR_J_LO: rd_mux = j_reg[7:0];
            ADDR_J_HI: rd_mux = j_reg[15:8];
            ADDR_K_LO: rd_mux = k_reg[7:0];
            ADDR_K_HI: rd_mux = k_reg[15:8];
            ADDR_STAT:
            begin
                rd_mux = '0;
                rd_mux[STAT_CARRY_BIT]    = carry_reg;
                rd_mux[STAT_OVERFLOW_BIT] = ovf_reg;
            end
            default:   rd_mux = UNMAPPED_BYTE;
        endcase
    end

    always_comb
    begin
        c_next = c_reg; d_next = d_reg; e_next = e_reg; f_next = f_reg;
        g_next = g_reg; h_next = h_reg; j_next = j_reg; k_next = k_reg;
        carry_next = carry_reg;
        ovf_next   = ovf_reg;
        prod_next  = prod_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;

        if (cmd.reg_write)
        begin
            case (reg_addr)
                ADDR_C_LO: c_next[7:0]  = write_byte;
                ADDR_C_HI: c_next[15:8] = write_byte;
                ADDR_D_LO: d_next[7:0]  = write_byte;
                ADDR_D_HI: d_next[15:8] = write_byte;
                ADDR_E_LO: e_next[7:0]  = write_byte;
                ADDR_E_HI: e_next[15:8] = write_byte;
                ADDR_F_LO: f_next[7:0]  = write_byte;
                ADDR_F_HI: f_next[15:8] = write_byte;
                ADDR_G_LO: g_next[7:0]  = write_byte;
                ADDR_G_HI: g_next[15:8] = write_byte;
                ADDR_H_LO: h_next[7:0]  = write_byte;
                ADDR_H_HI: h_next[15:8] = write_byte;
                ADDR_J_LO: j_next[7:0]  = write_byte;
                ADDR_J_HI: j_next[15:8] = write_byte;
                ADDR_K_LO: k_next[7:0]  = write_byte;
                ADDR_K_HI: k_next[15:8] = write_byte;
                default:   ;
            endcase
        end

        if (cmd.mul_start)
        begin
            prod_next = mag_c * mag_e;
            neg_next  = signed_reg && (c_reg[15] != e_reg[15]);
        end

        if (cmd.mul_fix && neg_reg)
        begin
            prod_next = 32'd0 - prod_reg;
        end

        if (cmd.mul_acc)
        begin
            if (accum_reg)
            begin
                {g_next, h_next} = acc_sum[31:0];
                carry_next = acc_sum[32];
                ovf_next   = acc_sum[32];
            end
            else
            begin
                {g_next, h_next} = prod_reg;
                carry_next = 1'b0;
                ovf_next   = 1'b0;
            end
        end

        if (cmd.div_pre)
        begin
            if (e_reg == 16'd0)
            begin
                c_next = '0; d_next = '0; g_next = '0; h_next = '0;
            end
            dvd_next = mag_gh;
            dvs_next = mag_e;
            rem_next = '0;
            neg_next = signed_reg && (gh[31] != e_reg[15]);
        end

        if (cmd.div_step)
        begin
            if (!diff[16])
            begin
                rem_next = diff[15:0];
                dvd_next = {dvd_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = part[15:0];
                dvd_next = {dvd_reg[30:0], 1'b0};
            end
        end

        if (cmd.div_post)
        begin
            c_next = quo[15:0];
            d_next = quo[31:16];
            g_next = rem_reg;
            h_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg <= '0; d_reg <= '0; e_reg <= '0; f_reg <= '0;
            g_reg <= '0; h_reg <= '0; j_reg <= '0; k_reg <= '0;
            carry_reg  <= 1'b0;
            ovf_reg    <= 1'b0;
            signed_reg <= 1'b0;
            accum_reg  <= 1'b0;
        end
        else
        begin
            c_reg <= c_next; d_reg <= d_next; e_reg <= e_next; f_reg <= f_next;
            g_reg <= g_next; h_reg <= h_next; j_reg <= j_next; k_reg <= k_next;
            carry_reg <= carry_next;
            ovf_reg   <= ovf_next;
            if (cfg_we && cfg_index == CFG_SIGNED_MODE)
            begin
                signed_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_ACCUM_MODE)
            begin
                accum_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        if (cmd.load_out)
        begin
            out_reg <= (op == OP_WRITE) ? 8'h00 : rd_mux;
        end
    end

    assign read_byte = out_reg;

endmodule
`default_nettype wire

// ===== hdl/math_coprocessor_mul_div_unit.sv =====
`default_nettype none
// Byte-wide register front end for a 16-bit multiply / accumulate / divide
// unit. Each input beat is one register access (read or write) and returns
// exactly one output beat: the byte read, 0xFF for an unmapped offset, or 0
// for any write. The math registers C..K sit at 0x60-0x73 and status at
// 0x92 (carry in bit 2, overflow in bit 5). Writing 0x67 (F high) starts
// C*E into G:H, with optional accumulate; writing 0x73 (K high) starts a
// G:H / E divide, quotient to D:C and remainder to G. Signed mode works
// on two's-complement operands (0x8000 keeps magnitude 0x8000), and the
// remainder is never negated. A plain access leaves the sequencer idle;
// the multiply keeps the input stalled through its steps (product, sign
// fix, accumulate); the divide keeps it stalled through the steps of the
// one-bit-per-cycle restoring divider (setup, 32 steps, sign fix), or
// through setup alone when E is zero. The result beat is presented in the
// cycle after the access is accepted, while any started operation runs on.
module math_coprocessor_mul_div_unit
    import mcmd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic       cfg_data,
    // access channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       op,
    input  wire logic [7:0] reg_addr,
    input  wire logic [7:0] write_byte,
    // result channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      read_byte
);

    mcmd_cmd_t cmd;
    mcmd_sts_t sts;

    // Sequencer: handshakes and operation steps
    mcmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .reg_addr  (reg_addr),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Register file, multiplier, serial divider, read mux
    mcmd_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (op),
        .reg_addr   (reg_addr),
        .write_byte (write_byte),
        .cmd        (cmd),
        .sts        (sts),
        .read_byte  (read_byte)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import mcmd_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 12;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 97;
    // divide runs setup + DIV_STEPS + sign fix; leave margin past that
    localparam int SETTLE_CYCLES  = DIV_STEPS + 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_DIRECTED   = 27;

    // one directed access: mode to run it in, the access itself, and an
    // optional hand-typed result byte (typed == 0 means use the mirror)
    typedef struct packed {
        logic       sig;
        logic       acc;
        logic       wr;
        logic [7:0] addr;
        logic [7:0] data;
        logic       typed;
        logic [7:0] expb;
    } dir_row_t;

    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        // after reset: everything reads zero, holes read 0xFF
        '{1'b0, 1'b0, OP_READ,  ADDR_C_LO, 8'h00, 1'b1, 8'h00},
        '{1'b0, 1'b0, OP_READ,  ADDR_STAT, 8'h00, 1'b1, 8'h00},
        '{1'b0, 1'b0, OP_READ,  8'h00,     8'h00, 1'b1, UNMAPPED_BYTE},
        '{1'b0, 1'b0, OP_READ,  8'hFF,     8'h00, 1'b1, UNMAPPED_BYTE},
        '{1'b0, 1'b0, OP_READ,  8'h68,     8'h00, 1'b1, UNMAPPED_BYTE},
        // status write is a no-op
        '{1'b0, 1'b0, OP_WRITE, ADDR_STAT, 8'hFF, 1'b1, 8'h00},
        // unsigned 0xFFFF * 0xFFFF, then divide the product back by E
        '{1'b0, 1'b0, OP_WRITE, ADDR_C_LO, 8'hFF, 1'b1, 8'h00},
        '{1'b0, 1'b0, OP_WRITE, ADDR_C_HI, 8'hFF, 1'b1, 8'h00},
        '{1'b0, 1'b0, OP_WRITE, ADDR_E_LO, 8'hFF, 1'b1, 8'h00},
        '{1'b0, 1'b0, OP_WRITE, ADDR_E_HI, 8'hFF, 1'b1, 8'h00},
        '{1'b0, 1'b0, OP_WRITE, ADDR_F_HI, 8'h00, 1'b1, 8'h00},
        '{1'b0, 1'b0, OP_READ,  ADDR_G_HI, 8'h00, 1'b0, 8'h00},
        '{1'b0, 1'b0, OP_READ,  ADDR_H_LO, 8'h00, 1'b0, 8'h00},
        '{1'b0, 1'b0, OP_WRITE, ADDR_K_HI, 8'h80, 1'b1, 8'h00},
        '{1'b0, 1'b0, OP_READ,  ADDR_C_HI, 8'h00, 1'b0, 8'h00},
        // signed + accumulate: 0x8000 keeps its magnitude, times -1
        '{1'b1, 1'b1, OP_WRITE, ADDR_C_LO, 8'h00, 1'b1, 8'h00},
        '{1'b1, 1'b1, OP_WRITE, ADDR_C_HI, 8'h80, 1'b1, 8'h00},
        '{1'b1, 1'b1, OP_WRITE, ADDR_F_HI, 8'h7F, 1'b1, 8'h00},
        '{1'b1, 1'b1, OP_READ,  ADDR_STAT, 8'h00, 1'b0, 8'h00},
        // negative dividend over -1: remainder stays unsigned
        '{1'b1, 1'b1, OP_WRITE, ADDR_G_HI, 8'hFF, 1'b1, 8'h00},
        '{1'b1, 1'b1, OP_WRITE, ADDR_K_HI, 8'h01, 1'b1, 8'h00},
        '{1'b1, 1'b1, OP_READ,  ADDR_G_LO, 8'h00, 1'b0, 8'h00},
        // divide by zero clears C, D, G, H and leaves the flags alone
        '{1'b1, 1'b1, OP_WRITE, ADDR_E_LO, 8'h00, 1'b1, 8'h00},
        '{1'b1, 1'b1, OP_WRITE, ADDR_E_HI, 8'h00, 1'b1, 8'h00},
        '{1'b1, 1'b1, OP_WRITE, ADDR_K_HI, 8'h00, 1'b1, 8'h00},
        '{1'b1, 1'b1, OP_READ,  ADDR_D_HI, 8'h00, 1'b1, 8'h00},
        '{1'b1, 1'b1, OP_READ,  ADDR_STAT, 8'h00, 1'b0, 8'h00}
    };

    // per phase mode: bit 1 signed, bit 0 accumulate
    localparam logic [1:0] PHASE_MODE [NUM_PHASES] = '{
        2'b00, 2'b10, 2'b11, 2'b01, 2'b11, 2'b00, 2'b10, 2'b01
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic       cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic       op;
    logic [7:0] reg_addr;
    logic [7:0] write_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] read_byte;

    math_coprocessor_mul_div_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .reg_addr   (reg_addr),
        .write_byte (write_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_byte  (read_byte)
    );

    // mirror of the register file, flags and mode bits
    logic [15:0] mirror_c, mirror_d, mirror_e, mirror_f;
    logic [15:0] mirror_g, mirror_h, mirror_j, mirror_k;
    logic        mirror_ovf, mirror_cry;
    logic        mirror_signed, mirror_accum;

    // read bytes owed by the block, oldest first
    logic [7:0] read_bytes_due [$];
    logic [7:0] due_byte;

    int  n_fail;
    int  items_sent;
    int  stuck_cycles;
    int  send_idle_pct;
    int  rcv_idle_pct;
    int  hold_left;
    bit  hold_req;
    bit  hold_done;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // C * E into G:H; two's-complement operands when signed, optional
    // 32-bit accumulate whose carry-out sets both flags
    function automatic void mirror_multiply();
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] prod;
        logic [32:0] sum;
        logic        neg;
        ma         = {16'h0000, mirror_c};
        mb         = {16'h0000, mirror_e};
        neg        = 1'b0;
        mirror_ovf = 1'b0;
        mirror_cry = 1'b0;
        if (mirror_signed)
        begin
            if (mirror_c[15])
                ma = {16'h0000, 16'(~mirror_c + 16'd1)};
            if (mirror_e[15])
                mb = {16'h0000, 16'(~mirror_e + 16'd1)};
            neg = mirror_c[15] ^ mirror_e[15];
        end
        prod = ma * mb;
        if (neg)
            prod = ~prod + 32'd1;
        if (mirror_accum)
        begin
            sum = {1'b0, prod} + {1'b0, mirror_g, mirror_h};
            if (sum[32])
            begin
                mirror_ovf = 1'b1;
                mirror_cry = 1'b1;
            end
            prod = sum[31:0];
        end
        mirror_g = prod[31:16];
        mirror_h = prod[15:0];
    endfunction

    // G:H / E; quotient to D:C, remainder (never negated) to G, H cleared
    function automatic void mirror_divide();
        logic [31:0] dvd;
        logic [31:0] dvs;
        logic [31:0] quo;
        logic [31:0] rem;
        logic        neg;
        if (mirror_e == 16'h0000)
        begin
            mirror_c = 16'h0000;
            mirror_d = 16'h0000;
            mirror_g = 16'h0000;
            mirror_h = 16'h0000;
        end
        else
        begin
            dvd = {mirror_g, mirror_h};
            dvs = {16'h0000, mirror_e};
            neg = 1'b0;
            if (mirror_signed)
            begin
                neg = mirror_g[15] ^ mirror_e[15];
                if (dvd[31])
                    dvd = ~dvd + 32'd1;
                if (mirror_e[15])
                    dvs = {16'h0000, 16'(~mirror_e + 16'd1)};
            end
            quo = dvd / dvs;
            rem = dvd % dvs;
            if (neg)
                quo = ~quo + 32'd1;
            mirror_c = quo[15:0];
            mirror_d = quo[31:16];
            mirror_g = rem[15:0];
            mirror_h = 16'h0000;
        end
    endfunction

    // apply one access to the mirror and return the byte the block owes
    function automatic logic [7:0] predict_access(input logic wr, input logic [7:0] a,
                                                  input logic [7:0] v);
        logic [7:0] rb;
        rb = 8'h00;
        if (wr == OP_WRITE)
        begin
            case (a)
                ADDR_C_LO: mirror_c[7:0]  = v;
                ADDR_C_HI: mirror_c[15:8] = v;
                ADDR_D_LO: mirror_d[7:0]  = v;
                ADDR_D_HI: mirror_d[15:8] = v;
                ADDR_E_LO: mirror_e[7:0]  = v;
                ADDR_E_HI: mirror_e[15:8] = v;
                ADDR_F_LO: mirror_f[7:0]  = v;
                ADDR_F_HI:
                begin
                    mirror_f[15:8] = v;
                    mirror_multiply();
                end
                ADDR_G_LO: mirror_g[7:0]  = v;
                ADDR_G_HI: mirror_g[15:8] = v;
                ADDR_H_LO: mirror_h[7:0]  = v;
                ADDR_H_HI: mirror_h[15:8] = v;
                ADDR_J_LO: mirror_j[7:0]  = v;
                ADDR_J_HI: mirror_j[15:8] = v;
                ADDR_K_LO: mirror_k[7:0]  = v;
                ADDR_K_HI:
                begin
                    mirror_k[15:8] = v;
                    mirror_divide();
                end
                default: ;
            endcase
        end
        else
        begin
            case (a)
                ADDR_C_LO: rb = mirror_c[7:0];
                ADDR_C_HI: rb = mirror_c[15:8];
                ADDR_D_LO: rb = mirror_d[7:0];
                ADDR_D_HI: rb = mirror_d[15:8];
                ADDR_E_LO: rb = mirror_e[7:0];
                ADDR_E_HI: rb = mirror_e[15:8];
                ADDR_F_LO: rb = mirror_f[7:0];
                ADDR_F_HI: rb = mirror_f[15:8];
                ADDR_G_LO: rb = mirror_g[7:0];
                ADDR_G_HI: rb = mirror_g[15:8];
                ADDR_H_LO: rb = mirror_h[7:0];
                ADDR_H_HI: rb = mirror_h[15:8];
                ADDR_J_LO: rb = mirror_j[7:0];
                ADDR_J_HI: rb = mirror_j[15:8];
                ADDR_K_LO: rb = mirror_k[7:0];
                ADDR_K_HI: rb = mirror_k[15:8];
                ADDR_STAT:
                begin
                    rb[STAT_CARRY_BIT]    = mirror_cry;
                    rb[STAT_OVERFLOW_BIT] = mirror_ovf;
                end
                default:   rb = UNMAPPED_BYTE;
            endcase
        end
        return rb;
    endfunction

    // Offer one access beat. Sender gaps are decided at each falling edge;
    // valid is raised once and held until the beat is taken. The mirror is
    // stepped at the accepting edge.
    task automatic send_access(input logic wr, input logic [7:0] a, input logic [7:0] v,
                               input logic typed, input logic [7:0] typed_byte);
        logic [7:0] predicted;
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= wr;
        reg_addr   <= a;
        write_byte <= v;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_access(wr, a, v);
        read_bytes_due.push_back(typed ? typed_byte : predicted);
        items_sent++;
    endtask

    task automatic wr_byte(input logic [7:0] a, input logic [7:0] v);
        send_access(OP_WRITE, a, v, 1'b0, 8'h00);
    endtask

    task automatic rd_byte(input logic [7:0] a);
        send_access(OP_READ, a, 8'($urandom), 1'b0, 8'h00);
    endtask

    // Drain, let any divide still running finish, then write both modes.
    task automatic apply_config(input logic sig, input logic acc);
        @(negedge clk);
        in_valid <= 1'b0;
        while (read_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SIGNED_MODE;
        cfg_data  <= sig;
        @(posedge clk);
        mirror_signed = sig;
        @(negedge clk);
        cfg_index <= CFG_ACCUM_MODE;
        cfg_data  <= acc;
        @(posedge clk);
        mirror_accum = acc;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // operands biased toward the two's-complement corners
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h7FFF;
            4:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_dividend();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return {16'h0000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // One random burst: mostly complete multiply / divide programs with
    // random operands, the rest stray accesses, cut-short programs and storage read-backs.
    task automatic run_sequence();
        logic [15:0] opa;
        logic [15:0] opb;
        logic [31:0] acc32;
        int          kind;
        int          n;
        kind = $urandom_range(9);
        if (kind <= 3)
        begin
            opa = pick_operand();
            opb = pick_operand();
            wr_byte(ADDR_C_LO, opa[7:0]);
            wr_byte(ADDR_C_HI, opa[15:8]);
            wr_byte(ADDR_E_LO, opb[7:0]);
            wr_byte(ADDR_E_HI, opb[15:8]);
            // without a preload the accumulator keeps running across bursts
            if ($urandom_range(1) == 1)
            begin
                acc32 = pick_dividend();
                wr_byte(ADDR_G_LO, acc32[23:16]);
                wr_byte(ADDR_G_HI, acc32[31:24]);
                wr_byte(ADDR_H_LO, acc32[7:0]);
                wr_byte(ADDR_H_HI, acc32[15:8]);
            end
            wr_byte(ADDR_F_LO, 8'($urandom));
            wr_byte(ADDR_F_HI, 8'($urandom));
            rd_byte(ADDR_G_HI);
            rd_byte(ADDR_G_LO);
            rd_byte(ADDR_H_HI);
            rd_byte(ADDR_H_LO);
            rd_byte(ADDR_STAT);
        end
        else if (kind <= 6)
        begin
            acc32 = pick_dividend();
            opb   = ($urandom_range(7) == 0) ? 16'h0000 : pick_operand();
            wr_byte(ADDR_G_LO, acc32[23:16]);
            wr_byte(ADDR_G_HI, acc32[31:24]);
            wr_byte(ADDR_H_LO, acc32[7:0]);
            wr_byte(ADDR_H_HI, acc32[15:8]);
            wr_byte(ADDR_E_LO, opb[7:0]);
            wr_byte(ADDR_E_HI, opb[15:8]);
            wr_byte(ADDR_K_LO, 8'($urandom));
            wr_byte(ADDR_K_HI, 8'($urandom));
            rd_byte(ADDR_C_LO);
            rd_byte(ADDR_C_HI);
            rd_byte(ADDR_D_LO);
            rd_byte(ADDR_D_HI);
            rd_byte(ADDR_G_LO);
            rd_byte(ADDR_G_HI);
            rd_byte(ADDR_H_LO);
            rd_byte(ADDR_H_HI);
            rd_byte(ADDR_STAT);
        end
        else if (kind == 7)
        begin
            // anything at all, anywhere in the byte space
            n = $urandom_range(4, 1);
            repeat (n)
                send_access(1'($urandom), 8'($urandom), 8'($urandom), 1'b0, 8'h00);
        end
        else if (kind == 8)
        begin
            // broken programs: random hits inside the math window and status
            n = $urandom_range(6, 1);
            repeat (n)
            begin
                if ($urandom_range(5) == 0)
                    send_access(1'($urandom), ADDR_STAT, 8'($urandom), 1'b0, 8'h00);
                else
                    send_access(1'($urandom), 8'(ADDR_C_LO + $urandom_range(19)),
                                8'($urandom), 1'b0, 8'h00);
            end
        end
        else
        begin
            // plain storage registers, written and read back
            opa = 16'($urandom);
            opb = 16'($urandom);
            wr_byte(ADDR_J_LO, opa[7:0]);
            wr_byte(ADDR_J_HI, opa[15:8]);
            wr_byte(ADDR_D_LO, opb[7:0]);
            wr_byte(ADDR_D_HI, opb[15:8]);
            wr_byte(ADDR_F_LO, 8'($urandom));
            wr_byte(ADDR_K_LO, 8'($urandom));
            rd_byte(ADDR_J_LO);
            rd_byte(ADDR_J_HI);
            rd_byte(ADDR_D_LO);
            rd_byte(ADDR_D_HI);
            rd_byte(ADDR_F_LO);
            rd_byte(ADDR_K_LO);
        end
    endtask

    // Receiver: random stall per cycle, plus one long hold-off on request
    // so the block backs up and stalls its input while beats keep coming.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (rcv_idle_pct != 0 && $urandom_range(99) < rcv_idle_pct);
    end

    // Result checker: every taken result beat against the oldest owed byte.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (read_bytes_due.size() == 0)
            begin
                $error("read_byte: result beat %02h with no access outstanding", read_byte);
                n_fail++;
            end
            else
            begin
                due_byte = read_bytes_due.pop_front();
                if (read_byte !== due_byte)
                begin
                    $error("read_byte: expected %02h, actual %02h", due_byte, read_byte);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: cycles in a row with no beat on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        int p;
        int r;
        int idle_mode;
        int phase_start;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SIGNED_MODE;
        cfg_data      = 1'b0;
        in_valid      = 1'b0;
        op            = OP_READ;
        reg_addr      = 8'h00;
        write_byte    = 8'h00;
        out_stall     = 1'b0;
        n_fail        = 0;
        items_sent    = 0;
        stuck_cycles  = 0;
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        hold_left     = 0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        mirror_c      = 16'h0000;
        mirror_d      = 16'h0000;
        mirror_e      = 16'h0000;
        mirror_f      = 16'h0000;
        mirror_g      = 16'h0000;
        mirror_h      = 16'h0000;
        mirror_j      = 16'h0000;
        mirror_k      = 16'h0000;
        mirror_ovf    = 1'b0;
        mirror_cry    = 1'b0;
        mirror_signed = 1'b0;
        mirror_accum  = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table, no idling; modes change only between rows
        for (r = 0; r < NUM_DIRECTED; r++)
        begin
            if (DIRECTED[r].sig !== mirror_signed || DIRECTED[r].acc !== mirror_accum)
                apply_config(DIRECTED[r].sig, DIRECTED[r].acc);
            send_access(DIRECTED[r].wr, DIRECTED[r].addr, DIRECTED[r].data,
                        DIRECTED[r].typed, DIRECTED[r].expb);
        end

        // random phases: sender-light/receiver-heavy idling, then the
        // reverse, then none (with the long receiver hold-off)
        for (p = 0; p < NUM_PHASES; p++)
        begin
            apply_config(PHASE_MODE[p][1], PHASE_MODE[p][0]);
            idle_mode = (p * 3) / NUM_PHASES;
            case (idle_mode)
                0:
                begin
                    send_idle_pct = 18;
                    rcv_idle_pct  = 67;
                end
                1:
                begin
                    send_idle_pct = 67;
                    rcv_idle_pct  = 18;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rcv_idle_pct  = 0;
                    hold_req      = 1'b1;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                run_sequence();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (read_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
